>>> rtl/fvdrg_pkg.sv
`default_nettype none
package fvdrg_pkg;
    localparam int COEF_W = 16;
    localparam int IDX_W  = 24;
    localparam int VAL_W  = 21;
    localparam int NFACE  = 6;
    localparam logic [1:0] CFG_CELLS = 2'd0;
    localparam logic [1:0] CFG_DIMS  = 2'd1;
    localparam logic [1:0] CFG_MASK  = 2'd2;
    localparam logic [VAL_W-1:0] VAL_MAX = 21'h0FFFFF;

    typedef struct packed {
        logic               present;
        logic [IDX_W-1:0]   column;
        logic [COEF_W-1:0]  mean;
    } face_t;
endpackage
`default_nettype wire

>>> rtl/fvdrg_divider.sv
`default_nettype none
module fvdrg_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [fvdrg_pkg::COEF_W-1:0] coef_a,
    input  wire logic [fvdrg_pkg::COEF_W-1:0] coef_b,
    output logic                            done,
    output logic [fvdrg_pkg::COEF_W-1:0]    mean
);
    import fvdrg_pkg::*;

    logic [33:0] rem_reg, rem_next;
    logic [33:0] quo_reg, quo_next;
    logic [17:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        zero_reg, zero_next;
    logic [34:0] shifted;
    logic [34:0] trial;
    logic [16:0] sum;
    logic [31:0] prod;

    assign sum  = {1'b0, coef_a} + {1'b0, coef_b};
    assign prod = coef_a * coef_b;
    assign shifted = {rem_reg, quo_reg[33]};
    assign trial = shifted - {17'd0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = {prod, 2'b00} + {17'd0, sum};
            den_next  = {sum, 1'b0};
            cnt_next  = 6'd34;
            busy_next = 1'b1;
            zero_next = (sum == 17'd0);
        end else if (busy_reg) begin
            quo_next = {quo_reg[32:0], ~trial[34]};
            rem_next = trial[34] ? shifted[33:0] : trial[33:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign mean = zero_reg ? '0 : quo_reg[COEF_W-1:0];
endmodule
`default_nettype wire

>>> rtl/fvdrg_merge.sv
`default_nettype none
module fvdrg_merge (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire fvdrg_pkg::face_t [fvdrg_pkg::NFACE-1:0] faces,
    input  wire logic [fvdrg_pkg::NFACE-1:0]   dirichlet,
    input  wire logic [fvdrg_pkg::COEF_W-1:0]  coef_center,
    input  wire logic [fvdrg_pkg::IDX_W-1:0]   row,
    input  wire logic                          final_cell,
    output logic                               busy,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [fvdrg_pkg::IDX_W-1:0]        m_row_index,
    output logic [fvdrg_pkg::IDX_W-1:0]        m_column_index,
    output logic signed [fvdrg_pkg::VAL_W-1:0] m_entry_value,
    output logic                               m_last_in_row,
    output logic                               m_last_in_matrix
);
    import fvdrg_pkg::*;

    face_t [NFACE-1:0] faces_reg;
    logic [IDX_W-1:0]  row_reg;
    logic              fin_reg;
    logic [22:0]       diag_reg, diag_next;
    logic [2:0]        sel_reg, sel_next;
    logic              busy_reg, busy_next;
    logic              v_reg, v_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic              lr_reg, lr_next, lm_reg, lm_next;
    logic [22:0]       diag_init;

    always_comb begin
        diag_init = '0;
        for (int f = 0; f < NFACE; f++) begin
            if (faces[f].present) begin
                diag_init = diag_init + {7'd0, faces[f].mean};
            end else if (dirichlet[f]) begin
                diag_init = diag_init + {6'd0, coef_center, 1'b0};
            end
        end
    end

    always_comb begin
        sel_next  = sel_reg;
        busy_next = busy_reg;
        v_next    = v_reg;
        col_next  = col_reg;
        val_next  = val_reg;
        lr_next   = lr_reg;
        lm_next   = lm_reg;
        diag_next = diag_reg;
        if (load) begin
            busy_next = 1'b1;
            sel_next  = '0;
            diag_next = diag_init;
        end
        if (busy_reg && (!v_reg || m_ready)) begin
            if (sel_reg == 3'(NFACE)) begin
                v_next    = 1'b1;
                col_next  = row_reg;
                val_next  = (diag_reg > {2'b00, VAL_MAX}) ? VAL_MAX : diag_reg[VAL_W-1:0];
                lr_next   = 1'b1;
                lm_next   = fin_reg;
                busy_next = 1'b0;
            end else begin
                v_next   = faces_reg[sel_reg].present;
                col_next = faces_reg[sel_reg].column;
                val_next = VAL_W'(0) - {5'd0, faces_reg[sel_reg].mean};
                lr_next  = 1'b0;
                lm_next  = 1'b0;
                sel_next = sel_reg + 3'd1;
            end
        end else if (v_reg && m_ready) begin
            v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            v_reg    <= 1'b0;
            sel_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            v_reg    <= v_next;
            sel_reg  <= sel_next;
        end
        if (load) begin
            faces_reg <= faces;
            row_reg   <= row;
            fin_reg   <= final_cell;
        end
        diag_reg <= diag_next;
        col_reg  <= col_next;
        val_reg  <= val_next;
        lr_reg   <= lr_next;
        lm_reg   <= lm_next;
    end

    assign busy             = busy_reg || v_reg;
    assign m_valid          = v_reg;
    assign m_row_index      = row_reg;
    assign m_column_index   = col_reg;
    assign m_entry_value    = val_reg;
    assign m_last_in_row    = lr_reg;
    assign m_last_in_matrix = lm_reg;
endmodule
`default_nettype wire

>>> rtl/fv_diffusion_row_generator_unit.sv
// An accepted word starts six parallel radix-2 dividers, each running 34 iterations;
// each divider then raises its done flag, and the done flags together load the merge.
// The merge steps through six face slots and the diagonal, one per cycle while the
// output does not stall, and the next word is taken only after the diagonal word
// leaves, so a new cell is not accepted before the last one is through.
// Reset (aresetn low, synchronous): registers to 256 cells, 3 dims, mask 63; walk at cell 0.
`default_nettype none
module fv_diffusion_row_generator_unit #(
    parameter int MAX_CELLS_PER_AXIS = 256,
    parameter int MAX_DIMS = 3
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [8:0]                    cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [fvdrg_pkg::COEF_W-1:0]  s_coef_center,
    input  wire logic [fvdrg_pkg::COEF_W-1:0]  s_coef_x_low,
    input  wire logic [fvdrg_pkg::COEF_W-1:0]  s_coef_x_high,
    input  wire logic [fvdrg_pkg::COEF_W-1:0]  s_coef_y_low,
    input  wire logic [fvdrg_pkg::COEF_W-1:0]  s_coef_y_high,
    input  wire logic [fvdrg_pkg::COEF_W-1:0]  s_coef_z_low,
    input  wire logic [fvdrg_pkg::COEF_W-1:0]  s_coef_z_high,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [fvdrg_pkg::IDX_W-1:0]        m_row_index,
    output logic [fvdrg_pkg::IDX_W-1:0]        m_column_index,
    output logic signed [fvdrg_pkg::VAL_W-1:0] m_entry_value,
    output logic                               m_last_in_row,
    output logic                               m_last_in_matrix
);
    import fvdrg_pkg::*;

    localparam int CW = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int PW = $clog2(MAX_CELLS_PER_AXIS);

    logic [8:0]  cells_reg;
    logic [1:0]  dims_reg;
    logic [5:0]  mask_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [PW-1:0] pos_reg [3];
    logic [CW-1:0] n_eff;
    logic [1:0]  d_eff;
    logic        calc_reg;
    logic        accept;
    logic        merge_busy;
    logic [NFACE-1:0] div_done;
    logic [COEF_W-1:0] means [NFACE];
    logic [COEF_W-1:0] nb [NFACE];
    logic [COEF_W-1:0] ctr_reg;
    face_t [NFACE-1:0] faces;
    logic [NFACE-1:0] pres_reg, pres_next;
    logic [NFACE-1:0] dir_reg, dir_next;
    logic [IDX_W-1:0] col_reg [NFACE];
    logic [IDX_W-1:0] col_next [NFACE];
    logic [IDX_W-1:0] row_reg;
    logic        fin_reg, fin_next;
    logic [IDX_W-1:0] stride;

    always_comb begin
        if (cells_reg == 9'd0) n_eff = CW'(1);
        else if ({23'd0, cells_reg} > MAX_CELLS_PER_AXIS) n_eff = CW'(MAX_CELLS_PER_AXIS);
        else n_eff = CW'(cells_reg);
        if (dims_reg == 2'd0) d_eff = 2'd1;
        else if ({30'd0, dims_reg} > MAX_DIMS) d_eff = 2'(MAX_DIMS);
        else d_eff = dims_reg;
    end

    assign nb[0] = s_coef_x_low;
    assign nb[1] = s_coef_x_high;
    assign nb[2] = s_coef_y_low;
    assign nb[3] = s_coef_y_high;
    assign nb[4] = s_coef_z_low;
    assign nb[5] = s_coef_z_high;

    assign s_ready = !calc_reg && !merge_busy && !cfg_we;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pres_next = '0;
        dir_next  = '0;
        fin_next  = 1'b1;
        stride    = IDX_W'(1);
        for (int i = 0; i < 3; i++) begin
            col_next[2*i]   = cnt_reg - stride;
            col_next[2*i+1] = cnt_reg + stride;
            if (i < int'(d_eff)) begin
                pres_next[2*i] = (pos_reg[i] != '0);
                dir_next[2*i]  = mask_reg[2*i];
                pres_next[2*i+1] = ({1'b0, pos_reg[i]} + CW'(1) < n_eff);
                dir_next[2*i+1]  = mask_reg[2*i+1];
                if ({1'b0, pos_reg[i]} + CW'(1) < n_eff) fin_next = 1'b0;
            end
            stride = IDX_W'(stride * n_eff);
        end
    end

    for (genvar g = 0; g < NFACE; g++) begin : g_lane
        fvdrg_divider u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (accept),
            .coef_a  (s_coef_center),
            .coef_b  (nb[g]),
            .done    (div_done[g]),
            .mean    (means[g])
        );
        assign faces[g].present  = pres_reg[g];
        assign faces[g].column   = col_reg[g];
        assign faces[g].mean     = means[g];
    end

    fvdrg_merge u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (calc_reg && (&div_done)),
        .faces            (faces),
        .dirichlet        (dir_reg & ~pres_reg),
        .coef_center      (ctr_reg),
        .row              (row_reg),
        .final_cell       (fin_reg),
        .busy             (merge_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_row_index      (m_row_index),
        .m_column_index   (m_column_index),
        .m_entry_value    (m_entry_value),
        .m_last_in_row    (m_last_in_row),
        .m_last_in_matrix (m_last_in_matrix)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_reg <= 9'd256;
            dims_reg  <= 2'd3;
            mask_reg  <= 6'd63;
            cnt_reg   <= '0;
            for (int i = 0; i < 3; i++) pos_reg[i] <= '0;
            calc_reg  <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_CELLS) cells_reg <= cfg_data;
            if (cfg_index == CFG_DIMS)  dims_reg  <= cfg_data[1:0];
            if (cfg_index == CFG_MASK)  mask_reg  <= cfg_data[5:0];
            if (cfg_index <= CFG_MASK) begin
                cnt_reg <= '0;
                for (int i = 0; i < 3; i++) pos_reg[i] <= '0;
            end
        end else begin
            if (calc_reg && (&div_done)) calc_reg <= 1'b0;
            if (accept) begin
                calc_reg <= 1'b1;
                if (fin_next) begin
                    cnt_reg <= '0;
                    for (int i = 0; i < 3; i++) pos_reg[i] <= '0;
                end else begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                    begin : adv
                        logic carry;
                        carry = 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            if (carry && i < int'(d_eff)) begin
                                if ({1'b0, pos_reg[i]} + CW'(1) < n_eff) begin
                                    pos_reg[i] <= pos_reg[i] + PW'(1);
                                    carry = 1'b0;
                                end else begin
                                    pos_reg[i] <= '0;
                                end
                            end
                        end
                    end
                end
            end
        end
        if (accept) begin
            pres_reg <= pres_next;
            dir_reg  <= dir_next;
            fin_reg  <= fin_next;
            row_reg  <= cnt_reg;
            ctr_reg  <= s_coef_center;
            for (int f = 0; f < NFACE; f++) col_reg[f] <= col_next[f];
        end
    end
endmodule
`default_nettype wire

>>> rtl/fvdrg_checker.sv
`default_nettype none
module fvdrg_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_last_in_row,
    input wire logic m_last_in_matrix,
    input wire logic [23:0] m_row_index,
    input wire logic [23:0] m_column_index
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column_index)) else $error("hold");
    a_mat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_in_matrix |-> m_last_in_row) else $error("matrix end");
    a_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_in_row |-> m_row_index == m_column_index) else $error("diag");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("busy");
endmodule
bind fv_diffusion_row_generator_unit fvdrg_checker u_chk (.*);
`default_nettype wire
